// ===== hw/rtl/lbs_pkg.sv =====
// Shared types, widths and helpers for the linear blend skinning block.
`timescale 1ns / 1ps

package lbs_pkg;

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int BONE_W     = 6;
  localparam int ENTRY_W    = 4;
  localparam int MAX_INFL   = 4;
  localparam int MAT_ELEMS  = 12;

  // Parameter defaults
  localparam int PALETTE_SIZE_DEF = 64;
  localparam int INFLUENCES_DEF   = 4;

  // Shared multiplier operands and product
  localparam int MUL_IN_W  = 33;
  localparam int PROD_W    = 64;

  // Address of the largest palette before trimming to the real depth
  localparam int FULL_ADDR_W = 10;

  // Width of the values that get saturated
  localparam int SAT_IN_W = 50;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [MUL_IN_W-1:0] mul_in_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic coord_t sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(signed'(32'sh7fff_ffff));
    lo = SAT_IN_W'(signed'(32'sh8000_0000));
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lbs_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module lbs_mul
  import lbs_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  mul_in_t a,
  input  mul_in_t b,
  output prod_t   prod
);

  logic signed [2*MUL_IN_W-1:0] full;

  assign full = a * b;

  // Products used here always fit in 64 signed bits
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[PROD_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/linear_blend_skinning.sv =====
// Top level: four-influence linear blend skinning against a bone palette.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall    | action, palette_*, pos_*, bone_*
//  out     | output    | out_valid / out_stall  | skinned_x, skinned_y, skinned_z
//  cfg     | input     | cfg_we                 | cfg_wdata (weight_threshold)
//
// A load transaction writes the palette RAM directly.
// A vertex is processed one bone at a time: each of the three coordinates of a bone
// goes through the one shared multiplier (three row products, translation add,
// weight product), after a check state for that bone.
// rst (synchronous) clears the sequencer and output valid and sets the threshold
// to 1; palette contents are undefined until loaded. A finished result waits in
// the output register under out_stall while the next transaction is already accepted.
`timescale 1ns / 1ps

module linear_blend_skinning
  import lbs_pkg::*;
#(
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF,
  parameter int INFLUENCES   = INFLUENCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [BONE_W-1:0]          palette_slot,
  input  logic [ENTRY_W-1:0]         palette_entry,
  input  logic signed [COORD_W-1:0]  palette_value,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic signed [COORD_W-1:0]  pos_z,
  input  logic [MAX_INFL*BONE_W-1:0] bone_ids,
  input  logic [MAX_INFL*WEIGHT_W-1:0] bone_weights,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  skinned_x,
  output logic signed [COORD_W-1:0]  skinned_y,
  output logic signed [COORD_W-1:0]  skinned_z,
  // configuration
  input  logic                       cfg_we,
  input  logic [WEIGHT_W-1:0]        cfg_wdata
);

  localparam int DEPTH  = PALETTE_SIZE * MAT_ELEMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = 65;
  localparam int ACC_W  = 36;
  localparam int K_W    = 3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_INF  = 9'b0_0000_0010,
    S_RD   = 9'b0_0000_0100,
    S_MUL  = 9'b0_0000_1000,
    S_ACC  = 9'b0_0001_0000,
    S_TRN  = 9'b0_0010_0000,
    S_WMUL = 9'b0_0100_0000,
    S_WACC = 9'b0_1000_0000,
    S_DONE = 9'b1_0000_0000
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0]           threshold;
  coord_t                        px, py, pz;
  logic [MAX_INFL*BONE_W-1:0]    ids;
  logic [MAX_INFL*WEIGHT_W-1:0]  wts;
  logic [K_W-1:0]                k;
  logic [1:0]                    r;
  logic [1:0]                    j;
  logic [FULL_ADDR_W-1:0]        base;
  logic [WEIGHT_W-1:0]           cur_w;
  logic signed [SUM_W-1:0]       sum;
  coord_t                        c;
  logic signed [ACC_W-1:0]       acc [3];

  logic                          in_acc;
  logic                          ram_we;
  logic [FULL_ADDR_W-1:0]        waddr_full;
  logic [FULL_ADDR_W-1:0]        raddr_full;
  logic [ENTRY_W-1:0]            elem;
  logic [COORD_W-1:0]            rdata;
  logic [BONE_W-1:0]             k_bone;
  logic [WEIGHT_W-1:0]           k_wt;
  coord_t                        p_row;
  logic                          mul_en;
  mul_in_t                       mul_a, mul_b;
  prod_t                         prod;
  logic signed [SAT_IN_W-1:0]    trn;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Palette write address: slot * 12 + entry
  assign waddr_full = FULL_ADDR_W'({palette_slot, 3'b000}) +
                      FULL_ADDR_W'({palette_slot, 2'b00}) +
                      FULL_ADDR_W'(palette_entry);
  assign ram_we = in_acc && !action &&
                  ({1'b0, palette_slot} < (BONE_W+1)'(PALETTE_SIZE)) &&
                  (palette_entry < ENTRY_W'(MAT_ELEMS));

  // Read address: bone base + row * 3 + column
  assign elem       = ENTRY_W'({r, 1'b0}) + ENTRY_W'(r) + ENTRY_W'(j);
  assign raddr_full = base + FULL_ADDR_W'(elem);

  lbs_ram #(
    .WIDTH (COORD_W),
    .DEPTH (DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (palette_value),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Current influence fields
  assign k_bone = ids[BONE_W*k[1:0] +: BONE_W];
  assign k_wt   = wts[WEIGHT_W*k[1:0] +: WEIGHT_W];

  // Position row feeding the multiplier
  always_comb begin
    case (r)
      2'd0:    p_row = px;
      2'd1:    p_row = py;
      default: p_row = pz;
    endcase
  end

  // Shared multiplier operand select
  assign mul_en = (state == S_MUL) || (state == S_WMUL);
  always_comb begin
    if (state == S_WMUL) begin
      mul_a = MUL_IN_W'(c);
      mul_b = mul_in_t'({{(MUL_IN_W-WEIGHT_W){1'b0}}, cur_w});
    end else begin
      mul_a = MUL_IN_W'(p_row);
      mul_b = MUL_IN_W'(signed'(rdata));
    end
  end

  lbs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // floor(sum / 2^16) + translation
  assign trn = SAT_IN_W'(signed'(sum[SUM_W-1:16])) + SAT_IN_W'(signed'(rdata));

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= WEIGHT_W'(1);
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output valid: set by a finished vertex, cleared once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && action) begin
            state <= S_INF;
          end
        end
        S_INF: begin
          if (k >= K_W'(INFLUENCES) || k_wt < threshold) begin
            state <= S_DONE;
          end else if ({1'b0, k_bone} >= (BONE_W+1)'(PALETTE_SIZE)) begin
            state <= S_INF;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (r == 2'd3) ? S_TRN : S_MUL;
        end
        S_MUL:  state <= S_ACC;
        S_ACC:  state <= S_RD;
        S_TRN:  state <= S_WMUL;
        S_WMUL: state <= S_WACC;
        S_WACC: begin
          state <= (j == 2'd2) ? S_INF : S_RD;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && action) begin
          px  <= pos_x;
          py  <= pos_y;
          pz  <= pos_z;
          ids <= bone_ids;
          wts <= bone_weights;
          k   <= '0;
          for (int i = 0; i < 3; i++) begin
            acc[i] <= '0;
          end
        end
      end
      S_INF: begin
        cur_w <= k_wt;
        base  <= FULL_ADDR_W'({k_bone, 3'b000}) + FULL_ADDR_W'({k_bone, 2'b00});
        j     <= '0;
        r     <= '0;
        sum   <= '0;
        if ({1'b0, k_bone} >= (BONE_W+1)'(PALETTE_SIZE)) begin
          k <= k + K_W'(1);
        end
      end
      S_ACC: begin
        sum <= sum + SUM_W'(prod);
        r   <= r + 2'd1;
      end
      S_TRN: begin
        c <= sat32(trn);
      end
      S_WACC: begin
        acc[j] <= acc[j] + prod[ACC_W+14:15];
        r      <= '0;
        sum    <= '0;
        if (j == 2'd2) begin
          k <= k + K_W'(1);
        end else begin
          j <= j + 2'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          skinned_x <= sat32(SAT_IN_W'(acc[0]));
          skinned_y <= sat32(SAT_IN_W'(acc[1]));
          skinned_z <= sat32(SAT_IN_W'(acc[2]));
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("palette written during a vertex");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && out_stall |=> state == S_DONE)
    else $error("result overwrote a pending output");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_INF |-> k <= K_W'(INFLUENCES))
    else $error("influence counter overran");

  a_wacc_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WACC |-> $past(state) == S_WMUL)
    else $error("weight accumulate without weight product");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> r != 2'd3)
    else $error("translation row sent to multiplier");

endmodule
